FILE: src/sobel_et_pkg.sv
// ----------------------------------------------------------------------------
// sobel_et_pkg: shared types and constants
// Word layouts, register indexes and defaults for the Sobel edge unit.
// ----------------------------------------------------------------------------
package sobel_et_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MIN_DIM       = 3;
    localparam int HEIGHT_W      = 12;
    localparam int ROW_W         = HEIGHT_W + 1;   // input row runs into the tail
    localparam int THR_W         = 11;
    localparam int THR_SQ_W      = 2 * THR_W;
    localparam int GRAD_W        = 11;             // |g| <= 1020
    localparam int SQ_W          = 20;             // 1020^2 < 2^20
    localparam int MAG_W         = SQ_W + 1;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam int RST_FRAME_WIDTH    = 640;
    localparam int RST_FRAME_HEIGHT   = 480;
    localparam int RST_EDGE_THRESHOLD = 50;

    localparam logic [7:0] EDGE_VALUE = 8'd255;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // one line store entry: pixel two rows up and one row up
    typedef struct packed {
        pixel_t up;
        pixel_t mid;
    } line_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       drain;
    } sobel_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       is_edge;
        logic       last_of_frame;
    } sobel_result_t;

    // word handed from front to back
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        pixel_t                   center;
        logic                     interior;
        logic                     last;
    } sobel_grad_t;

endpackage

FILE: src/sobel_et_queue.sv
// ----------------------------------------------------------------------------
// sobel_et_queue: gradient word queue
// Small FIFO between front and back; the front reserves space via level.
// ----------------------------------------------------------------------------
module sobel_et_queue
    import sobel_et_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  sobel_grad_t       wr_word,
    input  logic              rd_en,
    output sobel_grad_t       rd_word,
    output logic              nonempty,
    output logic [QCNT_W-1:0] level
);

    sobel_grad_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;
    logic              do_rd;

    assign nonempty = (count_reg != '0);
    assign level    = count_reg;
    assign rd_word  = entry_reg[rd_ptr_reg];
    assign do_rd    = rd_en && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

FILE: src/sobel_et_front.sv
// ----------------------------------------------------------------------------
// sobel_et_front: raster tracking, line stores and 3x3 window
// Accepts pixels, classifies output positions and forms gx / gy.
// ----------------------------------------------------------------------------
module sobel_et_front
    import sobel_et_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  sobel_item_t                    item,
    input  logic                           restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] frame_width,
    input  logic [HEIGHT_W-1:0]            frame_height,
    input  logic [QCNT_W-1:0]              level,
    output logic                           grad_push,
    output sobel_grad_t                    grad
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);

    // line stores, both rows in one word
    line_t              line_mem [MAX_WIDTH];
    line_t              rd_reg;
    logic               fwd_reg;
    line_t              fwd_line_reg;
    line_t              rd_eff;

    logic [IDX_W-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [IDX_W-1:0]    out_col_reg, out_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;

    logic                s1_v_reg;
    logic                s1_emit_reg;
    logic                s1_interior_reg;
    logic                s1_last_reg;
    logic [IDX_W-1:0]    s1_col_reg;
    pixel_t              s1_px_reg;
    logic                s2_v_reg;
    logic                s2_interior_reg;
    logic                s2_last_reg;

    pixel_t              win_reg [3][3];

    logic                accept, frame_in, active, had;
    logic                in_col_end, out_col_end, interior, last;
    pixel_t              px;
    logic [QCNT_W:0]     pending;
    logic [9:0]          gx_p, gx_n, gy_p, gy_n;

    assign pending = (QCNT_W+1)'(level) + (QCNT_W+1)'(s1_v_reg && s1_emit_reg)
                   + (QCNT_W+1)'(s2_v_reg);
    assign full    = (pending >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept  = push && !full;
    assign rd_eff  = fwd_reg ? fwd_line_reg : rd_reg;

    always_comb
    begin
        frame_in    = (in_row_reg < {1'b0, frame_height});
        active      = accept && !(item.drain && frame_in);
        px.red      = item.pixel_red;
        px.green    = item.pixel_green;
        px.blue     = item.pixel_blue;
        if (item.drain || !frame_in)
        begin
            px = '0;   // drain or tail push enters as black
        end
        had         = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        in_col_end  = (WW'(in_col_reg) == frame_width - WW'(1));
        out_col_end = (WW'(out_col_reg) == frame_width - WW'(1));
        interior    = (out_row_reg != '0) && (out_row_reg < frame_height - HEIGHT_W'(1))
                   && (out_col_reg != '0) && (WW'(out_col_reg) < frame_width - WW'(1));
        last        = (out_row_reg == frame_height - HEIGHT_W'(1)) && out_col_end;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (active)
        begin
            if (in_col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (had)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            fwd_reg     <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            s1_v_reg    <= active;
            s2_v_reg    <= s1_v_reg && s1_emit_reg;
            // same column read while it is being written: bypass the store
            fwd_reg     <= active && s1_v_reg && (s1_col_reg == in_col_reg);
            if (s1_v_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_eff.up;
                win_reg[1][2] <= rd_eff.mid;
                win_reg[2][2] <= s1_px_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (active)
        begin
            rd_reg          <= line_mem[in_col_reg];
            s1_col_reg      <= in_col_reg;
            s1_px_reg       <= px;
            s1_emit_reg     <= had;
            s1_interior_reg <= interior;
            s1_last_reg     <= last;
        end
        if (s1_v_reg)
        begin
            line_mem[s1_col_reg] <= '{up: rd_eff.mid, mid: s1_px_reg};
            fwd_line_reg         <= '{up: rd_eff.mid, mid: s1_px_reg};
            s2_interior_reg      <= s1_interior_reg;
            s2_last_reg          <= s1_last_reg;
        end
    end

    // Sobel sums on red
    always_comb
    begin
        gx_p = 10'(win_reg[0][2].red) + 10'({win_reg[1][2].red, 1'b0}) + 10'(win_reg[2][2].red);
        gx_n = 10'(win_reg[0][0].red) + 10'({win_reg[1][0].red, 1'b0}) + 10'(win_reg[2][0].red);
        gy_p = 10'(win_reg[0][0].red) + 10'({win_reg[0][1].red, 1'b0}) + 10'(win_reg[0][2].red);
        gy_n = 10'(win_reg[2][0].red) + 10'({win_reg[2][1].red, 1'b0}) + 10'(win_reg[2][2].red);
        grad.gx       = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
        grad.gy       = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
        grad.center   = win_reg[1][1];
        grad.interior = s2_interior_reg;
        grad.last     = s2_last_reg;
    end

    assign grad_push = s2_v_reg;

endmodule

FILE: src/sobel_et_back.sv
// ----------------------------------------------------------------------------
// sobel_et_back: magnitude test and result register
// Squares the gradients, compares against threshold squared, drives results.
// ----------------------------------------------------------------------------
module sobel_et_back
    import sobel_et_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grad_valid,
    input  sobel_grad_t         grad,
    output logic                grad_pop,
    input  logic [THR_SQ_W-1:0] thr_sq,
    output logic                empty,
    input  logic                pop,
    output sobel_result_t       result
);

    logic                b1_v_reg;
    logic [SQ_W-1:0]     b1_sqx_reg;
    logic [SQ_W-1:0]     b1_sqy_reg;
    pixel_t              b1_center_reg;
    logic                b1_interior_reg;
    logic                b1_last_reg;
    logic                res_v_reg;
    sobel_result_t       res_reg;

    logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
    logic [MAG_W-1:0]           mag;
    logic                       edge_hit;
    logic                       out_adv, b1_take;

    assign out_adv  = !res_v_reg || pop;
    assign b1_take  = !b1_v_reg || out_adv;
    assign grad_pop = grad_valid && b1_take;
    assign sqx_full = grad.gx * grad.gx;
    assign sqy_full = grad.gy * grad.gy;
    assign mag      = MAG_W'(b1_sqx_reg) + MAG_W'(b1_sqy_reg);
    assign edge_hit = b1_interior_reg && ({1'b0, mag} > thr_sq);
    assign empty    = !res_v_reg;
    assign result   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (b1_take)
            begin
                b1_v_reg <= grad_pop;
            end
            if (out_adv)
            begin
                res_v_reg <= b1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grad_pop)
        begin
            b1_sqx_reg      <= sqx_full[SQ_W-1:0];
            b1_sqy_reg      <= sqy_full[SQ_W-1:0];
            b1_center_reg   <= grad.center;
            b1_interior_reg <= grad.interior;
            b1_last_reg     <= grad.last;
        end
        if (out_adv && b1_v_reg)
        begin
            res_reg.out_red       <= edge_hit ? EDGE_VALUE : b1_center_reg.red;
            res_reg.out_green     <= edge_hit ? EDGE_VALUE : b1_center_reg.green;
            res_reg.out_blue      <= edge_hit ? EDGE_VALUE : b1_center_reg.blue;
            res_reg.is_edge       <= edge_hit;
            res_reg.last_of_frame <= b1_last_reg;
        end
    end

endmodule

FILE: src/sobel_edge_threshold_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold_unit: 3x3 Sobel edge marker on an RGB raster stream
// Marks interior pixels whose gradient magnitude exceeds a threshold.
// ----------------------------------------------------------------------------
//
//  channel   handshake             word
//  -------   -------------------   ---------------------------------------
//  input     push / full           item   : red, green, blue, drain
//  result    pop / empty           result : red, green, blue, edge, last
//  config    cfg_valid/cfg_ready   cfg_index (0 width, 1 height, 2 thresh)
//
//  One item per clock sustained while full is low. The push that completes
//  a window sends its result via window shift, queue write, square, compare.
//  Results lag the input by one row plus one pixel; drain words flush the tail.
//  The line stores are not cleared at reset; no clearing pass is needed.
//  full rises only when the gradient queue plus words in flight in the front
//  would overrun it, i.e. when the result side has stalled for a while.
//
module sobel_edge_threshold_unit
    import sobel_et_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  sobel_item_t            item,
    output logic                   empty,
    input  logic                   pop,
    output sobel_result_t          result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    // width clamped to [3, MAX_WIDTH]
    function automatic logic [WW-1:0] clamp_width(input logic [10:0] raw);
        logic [WW-1:0] w;
        if (32'(raw) < MIN_DIM)
        begin
            w = WW'(MIN_DIM);
        end
        else if (32'(raw) > MAX_WIDTH)
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(raw);
        end
        return w;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] raw);
        return (raw < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : raw;
    endfunction

    logic [WW-1:0]       width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;
    logic [THR_W-1:0]    thr_raw;
    logic                cfg_wr;
    logic                restart;

    logic                grad_push, grad_pop, grad_valid;
    sobel_grad_t         grad_in, grad_out;
    logic [QCNT_W-1:0]   level;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign thr_raw   = cfg_data[THR_W-1:0];
    // geometry writes restart the frame
    assign restart   = cfg_wr && ((cfg_index == REG_FRAME_WIDTH)
                               || (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_width(11'(RST_FRAME_WIDTH));
            height_reg <= HEIGHT_W'(RST_FRAME_HEIGHT);
            thr_sq_reg <= THR_SQ_W'(RST_EDGE_THRESHOLD * RST_EDGE_THRESHOLD);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:    width_reg  <= clamp_width(cfg_data[10:0]);
                REG_FRAME_HEIGHT:   height_reg <= clamp_height(cfg_data[HEIGHT_W-1:0]);
                REG_EDGE_THRESHOLD: thr_sq_reg <= THR_SQ_W'(thr_raw) * THR_SQ_W'(thr_raw);
                default:            ;
            endcase
        end
    end

    sobel_et_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .restart      (restart),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .level        (level),
        .grad_push    (grad_push),
        .grad         (grad_in)
    );

    sobel_et_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (grad_push),
        .wr_word  (grad_in),
        .rd_en    (grad_pop),
        .rd_word  (grad_out),
        .nonempty (grad_valid),
        .level    (level)
    );

    sobel_et_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (grad_valid),
        .grad       (grad_out),
        .grad_pop   (grad_pop),
        .thr_sq     (thr_sq_reg),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule
